>>> rtl/shift_operand_and_imm_expand_defines.svh
// Assertion macros used by the checker file of the operand shifter.
`ifndef SHIFT_OPERAND_AND_IMM_EXPAND_DEFINES_SVH
`define SHIFT_OPERAND_AND_IMM_EXPAND_DEFINES_SVH

// Plain property, checked at every rising edge outside reset.
`define SOIE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: when the antecedent holds, the consequent must follow.
`define SOIE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/soie_pkg.sv
// Types and constants of the operand shifter and immediate expander.
`default_nettype none

package soie_pkg;

    // Datapath width of the shifter.
    localparam int unsigned DATA_W = 32;
    // Width of the shift count field.
    localparam int unsigned AMT_W  = 8;
    // Width of the encoded modified immediate.
    localparam int unsigned IMM_W  = 12;

    // Request modes.
    typedef enum logic [1:0] {
        REQ_IMM_SHIFT = 2'd0,
        REQ_REG_SHIFT = 2'd1,
        REQ_MOD_IMM   = 2'd2
    } t_req_type;

    // Shift operations as encoded in the instruction.
    typedef enum logic [1:0] {
        SHK_LSL = 2'd0,
        SHK_LSR = 2'd1,
        SHK_ASR = 2'd2,
        SHK_ROR = 2'd3
    } t_shift_kind;

    // Byte replication patterns of an unrotated modified immediate.
    typedef enum logic [1:0] {
        REP_NONE  = 2'd0,
        REP_EVEN  = 2'd1,
        REP_ODD   = 2'd2,
        REP_ALL   = 2'd3
    } t_rep_pat;

    // Decoded shift control handed to the shifter core.
    typedef struct packed {
        t_shift_kind      kind;
        logic             rrx;
        logic [AMT_W-1:0] amount;
    } t_shift_ctrl;

    // Input word as held in the input register.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] operand_value;
        logic [1:0]        shift_kind;
        logic [AMT_W-1:0]  shift_amount;
        logic [IMM_W-1:0]  imm_twelve;
        logic              cflag_in;
    } t_req;

    // Result word as held in the output register.
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              cflag_out;
        logic              unpredictable;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/soie_if.sv
// Valid/ready channel interfaces for the request and result words.
`default_nettype none

// Request channel: one operand word per handshake.
interface soie_req_if;
    import soie_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [DATA_W-1:0] operand_value;
    logic [1:0]        shift_kind;
    logic [AMT_W-1:0]  shift_amount;
    logic [IMM_W-1:0]  imm_twelve;
    logic              cflag_in;

    modport source (
        output valid, req_type, operand_value, shift_kind, shift_amount,
               imm_twelve, cflag_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, operand_value, shift_kind, shift_amount,
               imm_twelve, cflag_in,
        output ready
    );
endinterface

// Result channel: one shifted or expanded word per handshake.
interface soie_rsp_if;
    import soie_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              cflag_out;
    logic              unpredictable;

    modport source (
        output valid, result_value, cflag_out, unpredictable,
        input  ready
    );

    modport sink (
        input  valid, result_value, cflag_out, unpredictable,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/shift_operand_and_imm_expand.sv
// Top level of the operand shifter: input register, shift/expand logic, output register.
//
// Usage:
//   Request words enter on i_req (valid/ready). Each word carries a mode:
//   immediate-encoded shift, shift by an explicit count, or modified
//   immediate expansion. Every request word yields exactly one result word
//   on o_rsp (valid/ready) with the 32-bit value, the carry out and a flag
//   for a replicated immediate whose byte is zero.
//   A word accepted on i_req is registered in the input register, goes
//   through the shifter or expander, and is registered in the output
//   register that drives o_rsp. Throughput is one word per cycle while
//   the receiver takes every result word, set by the single pass through
//   the input register, the barrel shifter and the output register. When
//   the receiver stalls, the result word holds on o_rsp and one more
//   request word is still taken into the input register; i_req.ready drops
//   only when both registers are full. Reset (i_rst_n low at a rising edge)
//   empties both registers; no state survives between words.
`default_nettype none

module shift_operand_and_imm_expand (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    soie_req_if.sink    i_req,
    soie_rsp_if.source  o_rsp
);
    import soie_pkg::*;

    logic              r_in_valid;
    t_req              r_in;
    logic              r_out_valid;
    t_rsp              r_out;
    t_rsp              n_out;

    logic              in_ready;
    logic              out_ready;
    t_shift_ctrl       shift_ctrl;
    logic [4:0]        imm5;
    logic [DATA_W-1:0] shift_value;
    logic              shift_carry;
    logic [DATA_W-1:0] imm_value;
    logic              imm_carry;
    logic              imm_unpred;

    // Each stage moves on when the stage after it is empty or draining.
    assign out_ready   = !r_out_valid || o_rsp.ready;
    assign in_ready    = !r_in_valid || out_ready;
    assign i_req.ready = in_ready;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_ready) begin
            r_in.req_type      <= i_req.req_type;
            r_in.operand_value <= i_req.operand_value;
            r_in.shift_kind    <= i_req.shift_kind;
            r_in.shift_amount  <= i_req.shift_amount;
            r_in.imm_twelve    <= i_req.imm_twelve;
            r_in.cflag_in      <= i_req.cflag_in;
        end
    end

    // Decode the shift: an immediate count of zero means 32 for LSR/ASR
    // and selects RRX for ROR.
    assign imm5 = r_in.shift_amount[4:0];

    always_comb begin
        shift_ctrl.kind   = t_shift_kind'(r_in.shift_kind);
        shift_ctrl.rrx    = 1'b0;
        shift_ctrl.amount = r_in.shift_amount;
        if (t_req_type'(r_in.req_type) == REQ_IMM_SHIFT) begin
            shift_ctrl.amount = {{(AMT_W-5){1'b0}}, imm5};
            if (imm5 == 5'd0) begin
                if (shift_ctrl.kind == SHK_LSR || shift_ctrl.kind == SHK_ASR) begin
                    shift_ctrl.amount = AMT_W'(DATA_W);
                end else if (shift_ctrl.kind == SHK_ROR) begin
                    shift_ctrl.rrx = 1'b1;
                end
            end
        end
    end

    soie_shift_core u_shift (
        .i_ctrl  (shift_ctrl),
        .i_value (r_in.operand_value),
        .i_carry (r_in.cflag_in),
        .o_value (shift_value),
        .o_carry (shift_carry)
    );

    soie_imm_expand u_imm (
        .i_imm           (r_in.imm_twelve),
        .i_carry         (r_in.cflag_in),
        .o_value         (imm_value),
        .o_carry         (imm_carry),
        .o_unpredictable (imm_unpred)
    );

    // Select the result by mode; the unused mode gives zero and keeps the carry.
    always_comb begin
        unique case (t_req_type'(r_in.req_type))
            REQ_IMM_SHIFT, REQ_REG_SHIFT: begin
                n_out.result_value  = shift_value;
                n_out.cflag_out     = shift_carry;
                n_out.unpredictable = 1'b0;
            end
            REQ_MOD_IMM: begin
                n_out.result_value  = imm_value;
                n_out.cflag_out     = imm_carry;
                n_out.unpredictable = imm_unpred;
            end
            default: begin
                n_out.result_value  = '0;
                n_out.cflag_out     = r_in.cflag_in;
                n_out.unpredictable = 1'b0;
            end
        endcase
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (r_in_valid && out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_value  = r_out.result_value;
    assign o_rsp.cflag_out     = r_out.cflag_out;
    assign o_rsp.unpredictable = r_out.unpredictable;

endmodule

`default_nettype wire

>>> rtl/soie_shift_core.sv
// Barrel shifter with carry out for LSL, LSR, ASR, ROR and RRX.
`default_nettype none

module soie_shift_core (
    input  wire soie_pkg::t_shift_ctrl          i_ctrl,
    input  wire logic [soie_pkg::DATA_W-1:0]    i_value,
    input  wire logic                           i_carry,
    output logic      [soie_pkg::DATA_W-1:0]    o_value,
    output logic                                o_carry
);
    import soie_pkg::*;

    localparam int unsigned CLAMP_W = $clog2(DATA_W) + 1;

    logic [DATA_W:0]     lsl_ext;
    logic [DATA_W:0]     lsr_ext;
    logic [DATA_W:0]     asr_ext;
    logic [2*DATA_W-1:0] ror_ext;
    logic [CLAMP_W-1:0]  asr_amt;

    // The extra bit on each shifted word catches the last bit shifted out.
    assign lsl_ext = {1'b0, i_value} << i_ctrl.amount;
    assign lsr_ext = {i_value, 1'b0} >> i_ctrl.amount;
    // Arithmetic shifts saturate at the full width: all sign bits.
    assign asr_amt = (i_ctrl.amount >= AMT_W'(DATA_W)) ? CLAMP_W'(DATA_W)
                                                      : i_ctrl.amount[CLAMP_W-1:0];
    assign asr_ext = $unsigned($signed({i_value, 1'b0}) >>> asr_amt);
    // Rotation uses the count modulo the width.
    assign ror_ext = {i_value, i_value} >> i_ctrl.amount[CLAMP_W-2:0];

    // Select the operation; RRX and a zero count take precedence.
    always_comb begin
        o_value = i_value;
        o_carry = i_carry;
        if (i_ctrl.rrx) begin
            o_value = {i_carry, i_value[DATA_W-1:1]};
            o_carry = i_value[0];
        end else if (i_ctrl.amount != '0) begin
            unique case (i_ctrl.kind)
                SHK_LSL: begin
                    o_value = lsl_ext[DATA_W-1:0];
                    o_carry = lsl_ext[DATA_W];
                end
                SHK_LSR: begin
                    o_value = lsr_ext[DATA_W:1];
                    o_carry = lsr_ext[0];
                end
                SHK_ASR: begin
                    o_value = asr_ext[DATA_W:1];
                    o_carry = asr_ext[0];
                end
                SHK_ROR: begin
                    o_value = ror_ext[DATA_W-1:0];
                    o_carry = ror_ext[DATA_W-1];
                end
                default: begin
                    o_value = i_value;
                    o_carry = i_carry;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/soie_imm_expand.sv
// Expansion of a 12-bit modified immediate into a 32-bit constant with carry.
`default_nettype none

module soie_imm_expand (
    input  wire logic [soie_pkg::IMM_W-1:0]  i_imm,
    input  wire logic                        i_carry,
    output logic      [soie_pkg::DATA_W-1:0] o_value,
    output logic                             o_carry,
    output logic                             o_unpredictable
);
    import soie_pkg::*;

    logic [7:0]          imm_byte;
    logic [DATA_W-1:0]   rot_base;
    logic [2*DATA_W-1:0] rot_ext;

    assign imm_byte = i_imm[7:0];
    // Rotated form: an 8-bit value with its top bit set, rotated right.
    assign rot_base = {24'd0, 1'b1, i_imm[6:0]};
    assign rot_ext  = {rot_base, rot_base} >> i_imm[11:7];

    // Replicated byte patterns keep the carry; rotated ones take bit 31.
    always_comb begin
        o_value         = rot_ext[DATA_W-1:0];
        o_carry         = rot_ext[DATA_W-1];
        o_unpredictable = 1'b0;
        if (i_imm[11:10] == 2'b00) begin
            o_carry = i_carry;
            unique case (t_rep_pat'(i_imm[9:8]))
                REP_NONE: o_value = {24'd0, imm_byte};
                REP_EVEN: o_value = {8'd0, imm_byte, 8'd0, imm_byte};
                REP_ODD:  o_value = {imm_byte, 8'd0, imm_byte, 8'd0};
                REP_ALL:  o_value = {imm_byte, imm_byte, imm_byte, imm_byte};
                default:  o_value = {24'd0, imm_byte};
            endcase
            o_unpredictable = (i_imm[9:8] != 2'b00) && (imm_byte == 8'd0);
        end
    end

endmodule

`default_nettype wire

>>> rtl/soie_checker.sv
// Port-level checks of the operand shifter, bound to its top level.
`default_nettype none

`include "shift_operand_and_imm_expand_defines.svh"

module soie_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire logic                        i_req_ready,
    input  wire logic                        i_rsp_valid,
    input  wire logic                        i_rsp_ready,
    input  wire logic [soie_pkg::DATA_W-1:0] i_result_value,
    input  wire logic                        i_unpredictable
);
    import soie_pkg::*;

    logic req_fire;
    logic rsp_stall;

    assign req_fire  = i_req_valid && i_req_ready;
    assign rsp_stall = i_rsp_valid && !i_rsp_ready;

    // A stalled result word stays valid and unchanged.
    `SOIE_ASSERT_IMP(a_rsp_hold, i_clk, i_rst_n, rsp_stall, ##1 (i_rsp_valid && $stable(i_result_value)), "stalled result word changed")

    // An accepted word is followed by a valid result word, with no allowance for a receiver stall.
    `SOIE_ASSERT_IMP(a_latency, i_clk, i_rst_n, req_fire, ##2 i_rsp_valid, "result word missing two cycles after request")

    // Backpressure only when the output register holds a word.
    `SOIE_ASSERT(a_ready_when_empty, i_clk, i_rst_n, i_req_ready || i_rsp_valid, "request ready low with empty output register")

    // A zero replicated byte expands to zero.
    `SOIE_ASSERT_IMP(a_unpred_zero, i_clk, i_rst_n, i_rsp_valid && i_unpredictable, i_result_value == '0, "unpredictable result is not zero")

endmodule

bind shift_operand_and_imm_expand soie_checker u_soie_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_result_value  (o_rsp.result_value),
    .i_unpredictable (o_rsp.unpredictable)
);

`default_nettype wire
